// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/gft_pkg.sv -----
// types, character codes and helper functions of the grammar file tokenizer
`default_nettype none
package gft_pkg;

   // position counter width
   localparam int POS_BITS = 16;
   localparam int OUT_BITS = 16;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [OUT_BITS-1:0] out_type;
   typedef logic [3:0]          kind_type;
   typedef logic [7:0]          char_type;

   // lexeme kinds
   localparam kind_type KIND_PERCENT   = 4'd0;
   localparam kind_type KIND_STAR      = 4'd1;
   localparam kind_type KIND_SLASH     = 4'd2;
   localparam kind_type KIND_LBRACE    = 4'd3;
   localparam kind_type KIND_RBRACE    = 4'd4;
   localparam kind_type KIND_PIPE      = 4'd5;
   localparam kind_type KIND_COLON     = 4'd6;
   localparam kind_type KIND_SEMICOLON = 4'd7;
   localparam kind_type KIND_KEYWORD   = 4'd8;
   localparam kind_type KIND_TEXT      = 4'd9;
   localparam kind_type KIND_BYTE      = 4'd10;

   // character codes
   localparam char_type CH_PERCENT   = 8'h25;
   localparam char_type CH_STAR      = 8'h2A;
   localparam char_type CH_SLASH     = 8'h2F;
   localparam char_type CH_LBRACE    = 8'h7B;
   localparam char_type CH_RBRACE    = 8'h7D;
   localparam char_type CH_PIPE      = 8'h7C;
   localparam char_type CH_COLON     = 8'h3A;
   localparam char_type CH_SEMICOLON = 8'h3B;
   localparam char_type CH_SPACE     = 8'h20;
   localparam char_type CH_NEWLINE   = 8'h0A;

   // keyword "token"
   localparam logic [2:0] KW_LEN = 3'd5;
   localparam char_type CH_T = 8'h74;
   localparam char_type CH_O = 8'h6F;
   localparam char_type CH_K = 8'h6B;
   localparam char_type CH_E = 8'h65;
   localparam char_type CH_N = 8'h6E;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } delim_type;

   typedef struct packed {
      kind_type lex_kind;
      out_type  lex_row;
      out_type  lex_column;
      out_type  word_length;
      char_type text_byte;
      out_type  lexeme_index;
      logic     last_of_run;
   } rsp_type;

   // single-character lexeme lookup
   function automatic delim_type delim_of(char_type b);
      delim_type d;
      d.hit = 1'b1;
      case (b)
         CH_PERCENT:   d.kind = KIND_PERCENT;
         CH_STAR:      d.kind = KIND_STAR;
         CH_SLASH:     d.kind = KIND_SLASH;
         CH_LBRACE:    d.kind = KIND_LBRACE;
         CH_RBRACE:    d.kind = KIND_RBRACE;
         CH_PIPE:      d.kind = KIND_PIPE;
         CH_COLON:     d.kind = KIND_COLON;
         CH_SEMICOLON: d.kind = KIND_SEMICOLON;
         default: begin
            d.hit  = 1'b0;
            d.kind = KIND_PERCENT;
         end
      endcase
      return d;
   endfunction

   // expected keyword character at a given match position
   function automatic char_type kw_char(logic [2:0] idx);
      char_type c;
      case (idx)
         3'd0:    c = CH_T;
         3'd1:    c = CH_O;
         3'd2:    c = CH_K;
         3'd3:    c = CH_E;
         3'd4:    c = CH_N;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // saturating increment of a position
   function automatic pos_type pos_inc(pos_type v);
      return (v == '1) ? v : v + pos_type'(1);
   endfunction

   // saturating sum of two positions
   function automatic pos_type pos_add(pos_type a, pos_type b);
      logic [POS_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
   endfunction

   // clamp a position to the output width
   function automatic out_type pos_clamp(pos_type v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'(out_type'('1))) ? '1 : w[OUT_BITS-1:0];
   endfunction

   // saturating increment of the lexeme counter
   function automatic out_type out_inc(out_type v);
      return (v == '1) ? v : v + out_type'(1);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/grammar_file_tokenizer_unit.sv -----
// grammar file tokenizer: byte classifier, position tracking and result queue
//
// req channel: one text byte (or an end-of-input flag) per beat, valid/ready.
// rsp channel: lexemes and echoed word bytes, one per beat, valid/ready.
// an input beat gives zero, one or two result beats; last_of_run marks the
// final one of a beat. a beat that closes a word on one of % { } | : ;
// gives the word lexeme followed by the delimiter lexeme.
// the whole classification and counter update happens in the accepting cycle,
// the results are registered into a four-entry queue that drives rsp.
// throughput is one input beat per cycle while each beat gives at most one
// result and rsp_ready stays high; a two-result beat leaves as two rsp beats.
// req_ready is high while the queue has two free entries, so a stalled
// receiver fills the queue and then holds off the sender; no beat is lost.
// reset (synchronous, active high) clears row, column, word and keyword
// tracking, the lexeme counter and the queue; no memory clearing is needed.
// end of input closes an open word and sets row and column back to zero
// while keeping the lexeme counter running.
`default_nettype none
`include "assert_macros.svh"
module grammar_file_tokenizer_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire gft_pkg::char_type  req_in_byte,
   input  wire logic               req_end_of_input,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output gft_pkg::kind_type       rsp_lex_kind,
   output gft_pkg::out_type        rsp_lex_row,
   output gft_pkg::out_type        rsp_lex_column,
   output gft_pkg::out_type        rsp_word_length,
   output gft_pkg::char_type       rsp_text_byte,
   output gft_pkg::out_type        rsp_lexeme_index,
   output logic                    rsp_last_of_run
);
   import gft_pkg::*;

   // tokenizer state
   pos_type    cur_row_ff, cur_row_in;
   pos_type    cur_column_ff, cur_column_in;
   logic       in_word_ff, in_word_in;
   pos_type    word_start_ff, word_start_in;
   pos_type    word_count_ff, word_count_in;
   logic [2:0] kw_progress_ff, kw_progress_in;
   logic       kw_failed_ff, kw_failed_in;
   out_type    lexeme_count_ff, lexeme_count_in;

   // result queue
   rsp_type                fifo_mem [FIFO_DEPTH];
   logic [PTR_BITS-1:0]    fifo_wr_ptr_ff, fifo_wr_ptr_in;
   logic [PTR_BITS-1:0]    fifo_rd_ptr_ff, fifo_rd_ptr_in;
   logic [CNT_BITS-1:0]    fifo_count_ff, fifo_count_in;
   logic [PTR_BITS-1:0]    wr_ptr_second;

   // per-beat decode
   logic       req_fire, rsp_fire;
   delim_type  dl;
   logic       is_space, is_newline, ends_word;
   logic       do_close, do_delim, do_byte;
   kind_type   word_kind;
   pos_type    col_after;
   out_type    lexeme_after_close;
   rsp_type    res_close, res_delim, res_byte;
   rsp_type    res_first, res_second;
   logic [1:0] push_count;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // byte classification
   always_comb begin
      dl         = delim_of(req_in_byte);
      is_space   = (req_in_byte == CH_SPACE);
      is_newline = (req_in_byte == CH_NEWLINE);
      ends_word  = is_space || is_newline ||
                   (dl.hit && (req_in_byte != CH_STAR) && (req_in_byte != CH_SLASH));
      do_close   = in_word_ff && (req_end_of_input || ends_word);
      do_byte    = !req_end_of_input && !ends_word && (in_word_ff || !dl.hit);
      do_delim   = !req_end_of_input && dl.hit && (!in_word_ff || ends_word);
      word_kind  = (!kw_failed_ff && (kw_progress_ff == KW_LEN)) ? KIND_KEYWORD : KIND_TEXT;
      col_after  = do_close ? pos_add(word_start_ff, word_count_ff) : cur_column_ff;
      lexeme_after_close = do_close ? out_inc(lexeme_count_ff) : lexeme_count_ff;
   end

   // candidate results
   always_comb begin
      res_close.lex_kind     = word_kind;
      res_close.lex_row      = pos_clamp(cur_row_ff);
      res_close.lex_column   = pos_clamp(word_start_ff);
      res_close.word_length  = pos_clamp(word_count_ff);
      res_close.text_byte    = '0;
      res_close.lexeme_index = lexeme_count_ff;
      res_close.last_of_run  = !do_delim;

      res_delim.lex_kind     = dl.kind;
      res_delim.lex_row      = pos_clamp(cur_row_ff);
      res_delim.lex_column   = pos_clamp(col_after);
      res_delim.word_length  = '0;
      res_delim.text_byte    = '0;
      res_delim.lexeme_index = lexeme_after_close;
      res_delim.last_of_run  = 1'b1;

      res_byte.lex_kind      = KIND_BYTE;
      res_byte.lex_row       = pos_clamp(cur_row_ff);
      res_byte.lex_column    = pos_clamp(cur_column_ff);
      res_byte.word_length   = '0;
      res_byte.text_byte     = req_in_byte;
      res_byte.lexeme_index  = '0;
      res_byte.last_of_run   = 1'b1;

      if (do_close) begin
         res_first = res_close;
      end else if (do_byte) begin
         res_first = res_byte;
      end else begin
         res_first = res_delim;
      end
      res_second = res_delim;
      push_count = 2'(do_close) + 2'(do_delim) + 2'(do_byte);
   end

   // next tokenizer state
   always_comb begin
      cur_row_in      = cur_row_ff;
      cur_column_in   = cur_column_ff;
      in_word_in      = in_word_ff;
      word_start_in   = word_start_ff;
      word_count_in   = word_count_ff;
      kw_progress_in  = kw_progress_ff;
      kw_failed_in    = kw_failed_ff;
      lexeme_count_in = lexeme_count_ff;
      if (req_fire) begin
         lexeme_count_in = lexeme_after_close;
         if (do_close) begin
            in_word_in     = 1'b0;
            word_count_in  = '0;
            kw_progress_in = '0;
            kw_failed_in   = 1'b0;
         end
         if (req_end_of_input) begin
            cur_row_in    = '0;
            cur_column_in = '0;
            word_start_in = '0;
         end else if (is_space) begin
            cur_column_in = pos_inc(col_after);
         end else if (is_newline) begin
            cur_row_in    = pos_inc(cur_row_ff);
            cur_column_in = '0;
         end else if (do_delim) begin
            cur_column_in   = pos_inc(col_after);
            lexeme_count_in = out_inc(lexeme_after_close);
         end else begin
            // word byte: a fresh word starts here, an open one grows
            in_word_in    = 1'b1;
            cur_column_in = pos_inc(cur_column_ff);
            word_count_in = pos_inc(word_count_ff);
            if (!in_word_ff) begin
               word_start_in = cur_column_ff;
            end
            if (!kw_failed_ff) begin
               if ((kw_progress_ff < KW_LEN) && (req_in_byte == kw_char(kw_progress_ff))) begin
                  kw_progress_in = kw_progress_ff + 3'd1;
               end else begin
                  kw_failed_in = 1'b1;
               end
            end
         end
      end
   end

   // queue pointers and fill level
   always_comb begin
      wr_ptr_second  = fifo_wr_ptr_ff + PTR_BITS'(1);
      fifo_wr_ptr_in = fifo_wr_ptr_ff;
      fifo_rd_ptr_in = fifo_rd_ptr_ff;
      if (req_fire) begin
         fifo_wr_ptr_in = fifo_wr_ptr_ff + PTR_BITS'(push_count);
      end
      if (rsp_fire) begin
         fifo_rd_ptr_in = fifo_rd_ptr_ff + PTR_BITS'(1);
      end
      fifo_count_in = fifo_count_ff + (req_fire ? CNT_BITS'(push_count) : '0)
                      - CNT_BITS'(rsp_fire);
   end

   // room for a two-result beat
   assign req_ready = (fifo_count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign rsp_valid = (fifo_count_ff != '0);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff      <= '0;
         cur_column_ff   <= '0;
         in_word_ff      <= 1'b0;
         word_start_ff   <= '0;
         word_count_ff   <= '0;
         kw_progress_ff  <= '0;
         kw_failed_ff    <= 1'b0;
         lexeme_count_ff <= '0;
         fifo_wr_ptr_ff  <= '0;
         fifo_rd_ptr_ff  <= '0;
         fifo_count_ff   <= '0;
      end else begin
         cur_row_ff      <= cur_row_in;
         cur_column_ff   <= cur_column_in;
         in_word_ff      <= in_word_in;
         word_start_ff   <= word_start_in;
         word_count_ff   <= word_count_in;
         kw_progress_ff  <= kw_progress_in;
         kw_failed_ff    <= kw_failed_in;
         lexeme_count_ff <= lexeme_count_in;
         fifo_wr_ptr_ff  <= fifo_wr_ptr_in;
         fifo_rd_ptr_ff  <= fifo_rd_ptr_in;
         fifo_count_ff   <= fifo_count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (req_fire && (push_count != 2'd0)) begin
         fifo_mem[fifo_wr_ptr_ff] <= res_first;
      end
      if (req_fire && (push_count == 2'd2)) begin
         fifo_mem[wr_ptr_second] <= res_second;
      end
   end

   // result beat
   always_comb begin
      rsp_lex_kind     = fifo_mem[fifo_rd_ptr_ff].lex_kind;
      rsp_lex_row      = fifo_mem[fifo_rd_ptr_ff].lex_row;
      rsp_lex_column   = fifo_mem[fifo_rd_ptr_ff].lex_column;
      rsp_word_length  = fifo_mem[fifo_rd_ptr_ff].word_length;
      rsp_text_byte    = fifo_mem[fifo_rd_ptr_ff].text_byte;
      rsp_lexeme_index = fifo_mem[fifo_rd_ptr_ff].lexeme_index;
      rsp_last_of_run  = fifo_mem[fifo_rd_ptr_ff].last_of_run;
   end

   // checks
   `ASSERT_SAME(a_fifo_bound, clock, reset, 1'b1, fifo_count_ff <= CNT_BITS'(FIFO_DEPTH))
   `ASSERT_SAME(a_open_word_nonempty, clock, reset, in_word_ff, word_count_ff != '0)
   `ASSERT_SAME(a_idle_keyword_clear, clock, reset, !in_word_ff, (kw_progress_ff == '0) && !kw_failed_ff)
   `ASSERT_NEXT(a_eof_clears_pos, clock, reset, req_fire && req_end_of_input, (cur_row_ff == '0) && (cur_column_ff == '0) && !in_word_ff)

endmodule
`default_nettype wire

// ----- tb/tb_grammar_file_tokenizer_unit.sv -----
// testbench of the grammar file tokenizer: streamed text beats, lexeme prediction, field checks
module tb_grammar_file_tokenizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import gft_pkg::*;

   localparam int RANDOM_BEATS = 420;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_LEN     = 300;
   localparam int CALM_LO      = 200;
   localparam int CALM_HI      = 330;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 20000;
   localparam string KEYWORD   = "token";

   typedef struct {
      char_type data;
      logic     eoi;
      bit       drain;
   } text_beat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   char_type req_in_byte = '0;
   logic     req_end_of_input = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   kind_type rsp_lex_kind;
   out_type  rsp_lex_row;
   out_type  rsp_lex_column;
   out_type  rsp_word_length;
   char_type rsp_text_byte;
   out_type  rsp_lexeme_index;
   logic     rsp_last_of_run;

   // text waiting to be sent and lexemes waiting to come back
   text_beat_type text_queue [$];
   rsp_type       lexeme_fifo [$];

   int beats_taken = 0;
   int mismatches  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   // tokenizer state as predicted
   pos_type    row_at = '0;
   pos_type    col_at = '0;
   pos_type    word_col = '0;
   pos_type    word_len = '0;
   logic       word_open = 1'b0;
   logic [2:0] kw_matched = '0;
   logic       kw_broken = 1'b0;
   out_type    lexemes_stored = '0;
   rsp_type    step_res [2];
   int         step_cnt;

   grammar_file_tokenizer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lex_kind     (rsp_lex_kind),
      .rsp_lex_row      (rsp_lex_row),
      .rsp_lex_column   (rsp_lex_column),
      .rsp_word_length  (rsp_word_length),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_lexeme_index (rsp_lexeme_index),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #10 clock = ~clock;

   // saturating position arithmetic
   function automatic pos_type bump(pos_type v);
      return (v == {POS_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic out_type narrow(pos_type v);
      return (64'(v) > 64'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : out_type'(v);
   endfunction

   // kind of a single-character lexeme, -1 when the byte is none
   function automatic int punct_kind(char_type b);
      case (b)
         CH_PERCENT:   return int'(KIND_PERCENT);
         CH_STAR:      return int'(KIND_STAR);
         CH_SLASH:     return int'(KIND_SLASH);
         CH_LBRACE:    return int'(KIND_LBRACE);
         CH_RBRACE:    return int'(KIND_RBRACE);
         CH_PIPE:      return int'(KIND_PIPE);
         CH_COLON:     return int'(KIND_COLON);
         CH_SEMICOLON: return int'(KIND_SEMICOLON);
         default:      return -1;
      endcase
   endfunction

   task automatic add_result(kind_type k, pos_type r, pos_type c, pos_type len,
                             char_type t, out_type idx);
      rsp_type e;
      e.lex_kind     = k;
      e.lex_row      = narrow(r);
      e.lex_column   = narrow(c);
      e.word_length  = narrow(len);
      e.text_byte    = t;
      e.lexeme_index = idx;
      e.last_of_run  = 1'b0;
      step_res[step_cnt] = e;
      step_cnt++;
   endtask

   // lexemes are numbered, the counter sticks at its top value
   task automatic store_lexeme(kind_type k, pos_type c, pos_type len);
      add_result(k, row_at, c, len, '0, lexemes_stored);
      if (lexemes_stored != {OUT_BITS{1'b1}})
         lexemes_stored++;
   endtask

   // a word byte is echoed and checked against the keyword
   task automatic echo_byte(char_type b);
      add_result(KIND_BYTE, row_at, col_at, '0, b, '0);
      if (!kw_broken) begin
         if (kw_matched < 3'(KEYWORD.len()) && b == char_type'(KEYWORD[kw_matched]))
            kw_matched++;
         else
            kw_broken = 1'b1;
      end
      word_len = bump(word_len);
      col_at   = bump(col_at);
   endtask

   task automatic close_word();
      logic [POS_BITS:0] sum;
      kind_type          k;
      k   = (!kw_broken && kw_matched == 3'(KEYWORD.len())) ? KIND_KEYWORD : KIND_TEXT;
      sum = {1'b0, word_col} + {1'b0, word_len};
      store_lexeme(k, word_col, word_len);
      col_at     = sum[POS_BITS] ? {POS_BITS{1'b1}} : sum[POS_BITS-1:0];
      word_open  = 1'b0;
      word_len   = '0;
      kw_matched = '0;
      kw_broken  = 1'b0;
   endtask

   // expected results of one accepted text beat
   task automatic tokenize_beat(char_type b, logic eoi);
      int   dk;
      logic breaks_word;
      step_cnt    = 0;
      dk          = punct_kind(b);
      breaks_word = (b == CH_SPACE) || (b == CH_NEWLINE) ||
                    (dk >= 0 && dk != int'(KIND_STAR) && dk != int'(KIND_SLASH));
      if (eoi) begin
         if (word_open)
            close_word();
         row_at   = '0;
         col_at   = '0;
         word_col = '0;
      end else if (word_open && !breaks_word) begin
         echo_byte(b);
      end else begin
         if (word_open)
            close_word();
         if (b == CH_SPACE) begin
            col_at = bump(col_at);
         end else if (b == CH_NEWLINE) begin
            row_at = bump(row_at);
            col_at = '0;
         end else if (dk >= 0) begin
            store_lexeme(kind_type'(dk), col_at, '0);
            col_at = bump(col_at);
         end else begin
            word_open  = 1'b1;
            word_col   = col_at;
            word_len   = '0;
            kw_matched = '0;
            kw_broken  = 1'b0;
            echo_byte(b);
         end
      end
      if (step_cnt > 0)
         step_res[step_cnt-1].last_of_run = 1'b1;
      for (int i = 0; i < step_cnt; i++)
         lexeme_fifo.push_back(step_res[i]);
   endtask

   task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic bit calm();
      return beats_taken >= CALM_LO && beats_taken < CALM_HI;
   endfunction

   // stimulus building
   task automatic push_beat(char_type d, logic eoi, bit drain = 1'b0);
      text_beat_type t;
      t.data  = d;
      t.eoi   = eoi;
      t.drain = drain;
      text_queue.push_back(t);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         push_beat(char_type'(s[i]), 1'b0);
   endtask

   function automatic char_type any_separator(int i);
      case (i)
         0:       return CH_SPACE;
         1:       return CH_NEWLINE;
         2:       return CH_PERCENT;
         3:       return CH_STAR;
         4:       return CH_SLASH;
         5:       return CH_LBRACE;
         6:       return CH_RBRACE;
         7:       return CH_PIPE;
         8:       return CH_COLON;
         default: return CH_SEMICOLON;
      endcase
   endfunction

   // any byte that opens a word
   function automatic char_type word_start_byte();
      char_type c;
      c = char_type'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_NEWLINE || punct_kind(c) >= 0)
         c = char_type'($urandom_range(0, 255));
      return c;
   endfunction

   // inner word bytes, now and then a star or slash that stays in the word
   task automatic push_random_word(int n);
      push_beat(word_start_byte(), 1'b0);
      for (int i = 1; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            push_beat($urandom_range(0, 1) ? CH_STAR : CH_SLASH, 1'b0);
         else
            push_beat(word_start_byte(), 1'b0);
      end
   endtask

   // mostly words with separators, some loose punctuation, noise and end marks
   task automatic add_random_chunk();
      int r;
      int w;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         w = $urandom_range(0, 5);
         case (w)
            0:       push_text(KEYWORD);
            1:       push_text(KEYWORD.substr(0, $urandom_range(0, 3)));
            2: begin
               push_text(KEYWORD);
               push_beat(word_start_byte(), 1'b0);
            end
            default: push_random_word($urandom_range(1, 8));
         endcase
         if ($urandom_range(0, 9) == 0)
            push_beat(char_type'($urandom_range(0, 255)), 1'b1);
         else
            push_beat(any_separator($urandom_range(0, 9)), 1'b0);
      end else if (r < 80) begin
         push_beat(any_separator($urandom_range(0, 9)), 1'b0);
      end else if (r < 92) begin
         push_beat(char_type'($urandom_range(0, 255)), 1'b0);
      end else begin
         push_beat(char_type'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // sender: a new beat may be offered once the previous one is taken
   always @(posedge clock) begin
      text_beat_type nxt;
      bit            offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tokenize_beat(req_in_byte, req_end_of_input);
            beats_taken++;
         end
         if (!req_valid || req_ready) begin
            offer = text_queue.size() > 0 && (calm() || $urandom_range(0, 99) >= 25);
            // a marked beat waits until every outstanding lexeme is back
            if (offer && text_queue[0].drain && lexeme_fifo.size() != 0)
               offer = 1'b0;
            if (offer) begin
               nxt = text_queue.pop_front();
               req_valid        <= 1'b1;
               req_in_byte      <= nxt.data;
               req_end_of_input <= nxt.eoi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver readiness, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && beats_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm() || $urandom_range(0, 99) >= 25;
      end
   end

   // result check against the oldest expected lexeme
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lexeme_fifo.size() == 0) begin
            flag_mismatch("result with nothing pending, kind", rsp_lex_kind, 0);
         end else begin
            want = lexeme_fifo.pop_front();
            if (rsp_lex_kind !== want.lex_kind)
               flag_mismatch("lex_kind", rsp_lex_kind, want.lex_kind);
            if (rsp_lex_row !== want.lex_row)
               flag_mismatch("lex_row", rsp_lex_row, want.lex_row);
            if (rsp_lex_column !== want.lex_column)
               flag_mismatch("lex_column", rsp_lex_column, want.lex_column);
            if (rsp_word_length !== want.word_length)
               flag_mismatch("word_length", rsp_word_length, want.word_length);
            if (rsp_text_byte !== want.text_byte)
               flag_mismatch("text_byte", rsp_text_byte, want.text_byte);
            if (rsp_lexeme_index !== want.lexeme_index)
               flag_mismatch("lexeme_index", rsp_lexeme_index, want.lexeme_index);
            if (rsp_last_of_run !== want.last_of_run)
               flag_mismatch("last_of_run", rsp_last_of_run, want.last_of_run);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int directed_n;

      // directed text: keyword closed by end of input, every punctuation mark,
      // space and newline, word carrying star and slash closed by a brace,
      // keyword prefix closed by a pipe, end of input with no open word
      push_text(KEYWORD);
      push_beat(8'h00, 1'b1);
      push_text("%*/{}|:;");
      push_text("\n ");
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_text("*/{");
      push_text("toke|");
      push_beat(8'hFF, 1'b1);
      directed_n = text_queue.size();

      // random text, started once the directed lexemes are all back
      push_beat(CH_SPACE, 1'b0, 1'b1);
      while (text_queue.size() < directed_n + RANDOM_BEATS)
         add_random_chunk();
      push_beat(8'h00, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sampled away from the rising edge so that sender updates have settled
      while (text_queue.size() != 0 || req_valid || lexeme_fifo.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gft_pkg.sv
rtl/grammar_file_tokenizer_unit.sv
tb/tb_grammar_file_tokenizer_unit.sv
